[src/rsfe_pkg.sv]
`timescale 1ns / 1ps

package rsfe_pkg;

   localparam int COLOR_W = 24;
   localparam int COUNT_W = 15;
   localparam int MODE_W  = 2;
   localparam int POS_W   = 7;
   localparam int CSR_W   = 2;
   localparam int DIR_W   = 3;

   localparam logic [COLOR_W-1:0] PAINT_RESET  = 24'h00FF00;
   localparam logic [COLOR_W-1:0] TARGET_RESET = 24'h000000;

   localparam logic [DIR_W-1:0] DIR_LAST_FLOOD    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_LAST_BOUNDARY = 3'd7;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } rsfe_mode_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_FILL_KIND    = 2'd0,
      CSR_PAINT_COLOR  = 2'd1,
      CSR_TARGET_COLOR = 2'd2,
      CSR_UNUSED       = 2'd3
   } rsfe_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_SEED,
      ST_SEED_CHK,
      ST_POP,
      ST_LOAD,
      ST_NBR,
      ST_CHECK,
      ST_RESULT
   } rsfe_state_type;

   typedef struct packed {
      logic x_inc;
      logic x_dec;
      logic y_inc;
      logic y_dec;
   } rsfe_step_type;

   typedef struct packed {
      logic          accept;
      rsfe_mode_type req_mode;
      logic          fill_skip;
      logic          item_inside;
      logic          qual;
      logic          nbr_ok;
      logic          last_dir;
      logic          level_zero;
      logic          out_free;
   } rsfe_status_type;

   typedef struct packed {
      logic req_ready;
      logic use_item;
      logic frame_rd;
      logic frame_wr;
      logic wr_item_color;
      logic push;
      logic pop;
      logic load_cur;
      logic dir_clr;
      logic dir_inc;
      logic count_one;
      logic count_inc;
      logic rsp_load;
   } rsfe_ctrl_type;

   // Neighbor order: right, down, left, up, then the four diagonals.
   function automatic rsfe_step_type dir_step(input logic [DIR_W-1:0] dir);
      rsfe_step_type s;
      s = '0;
      case (dir)
         3'd0: begin s.x_inc = 1'b1; end
         3'd1: begin s.y_inc = 1'b1; end
         3'd2: begin s.x_dec = 1'b1; end
         3'd3: begin s.y_dec = 1'b1; end
         3'd4: begin s.x_dec = 1'b1; s.y_dec = 1'b1; end
         3'd5: begin s.x_dec = 1'b1; s.y_inc = 1'b1; end
         3'd6: begin s.x_inc = 1'b1; s.y_dec = 1'b1; end
         3'd7: begin s.x_inc = 1'b1; s.y_inc = 1'b1; end
         default: begin s = '0; end
      endcase
      return s;
   endfunction

endpackage

[src/rsfe_nbr_unit.sv]
`timescale 1ns / 1ps

// Shared coordinate unit: steps a position one pixel, checks the frame edge
// and forms the linear pixel address.
module rsfe_nbr_unit #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 128
) (
   input  logic [$clog2(WIDTH)-1:0]          base_x,
   input  logic [$clog2(HEIGHT)-1:0]         base_y,
   input  rsfe_pkg::rsfe_step_type           step,
   output logic [$clog2(WIDTH)-1:0]          nbr_x,
   output logic [$clog2(HEIGHT)-1:0]         nbr_y,
   output logic                              in_frame,
   output logic [$clog2(WIDTH*HEIGHT)-1:0]   addr
);

   localparam int XW = $clog2(WIDTH);
   localparam int YW = $clog2(HEIGHT);
   localparam int CW = $clog2(WIDTH * HEIGHT);
   localparam logic [XW-1:0] X_MAX   = XW'(WIDTH - 1);
   localparam logic [YW-1:0] Y_MAX   = YW'(HEIGHT - 1);
   localparam logic [CW-1:0] ROW_LEN = CW'(WIDTH);

   logic x_lo, x_hi, y_lo, y_hi;

   assign x_lo = (base_x == '0);
   assign x_hi = (base_x == X_MAX);
   assign y_lo = (base_y == '0);
   assign y_hi = (base_y == Y_MAX);

   assign in_frame = !(step.x_dec && x_lo) && !(step.x_inc && x_hi) &&
                     !(step.y_dec && y_lo) && !(step.y_inc && y_hi);

   assign nbr_x = step.x_inc ? base_x + XW'(1) :
                  step.x_dec ? base_x - XW'(1) : base_x;
   assign nbr_y = step.y_inc ? base_y + YW'(1) :
                  step.y_dec ? base_y - YW'(1) : base_y;

   assign addr = CW'(nbr_y) * ROW_LEN + CW'(nbr_x);

endmodule

[src/rsfe_seq.sv]
`timescale 1ns / 1ps

// Fill sequencer: drives the coordinate unit, frame memory and stack.
module rsfe_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  rsfe_pkg::rsfe_status_type status,
   output rsfe_pkg::rsfe_ctrl_type   ctrl
);

   rsfe_pkg::rsfe_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsfe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsfe_pkg::ST_IDLE: begin
            if (status.accept) begin
               case (status.req_mode)
                  rsfe_pkg::MODE_WRITE: state_in = rsfe_pkg::ST_WRITE;
                  rsfe_pkg::MODE_FILL:  state_in = rsfe_pkg::ST_SEED;
                  rsfe_pkg::MODE_READ:  state_in = rsfe_pkg::ST_READ;
                  default:              state_in = rsfe_pkg::ST_RESULT;
               endcase
            end
         end
         rsfe_pkg::ST_WRITE: state_in = rsfe_pkg::ST_RESULT;
         rsfe_pkg::ST_READ:  state_in = rsfe_pkg::ST_RESULT;
         rsfe_pkg::ST_SEED: begin
            state_in = status.fill_skip ? rsfe_pkg::ST_RESULT : rsfe_pkg::ST_SEED_CHK;
         end
         rsfe_pkg::ST_SEED_CHK: begin
            state_in = status.qual ? rsfe_pkg::ST_POP : rsfe_pkg::ST_RESULT;
         end
         rsfe_pkg::ST_POP: begin
            state_in = status.level_zero ? rsfe_pkg::ST_RESULT : rsfe_pkg::ST_LOAD;
         end
         rsfe_pkg::ST_LOAD: state_in = rsfe_pkg::ST_NBR;
         rsfe_pkg::ST_NBR: begin
            if (status.nbr_ok) begin
               state_in = rsfe_pkg::ST_CHECK;
            end else if (status.last_dir) begin
               state_in = rsfe_pkg::ST_POP;
            end
         end
         rsfe_pkg::ST_CHECK: begin
            state_in = status.last_dir ? rsfe_pkg::ST_POP : rsfe_pkg::ST_NBR;
         end
         rsfe_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = rsfe_pkg::ST_IDLE;
            end
         end
         default: state_in = rsfe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.use_item = 1'b1;
      case (state_ff)
         rsfe_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
         end
         rsfe_pkg::ST_WRITE: begin
            ctrl.frame_wr      = status.item_inside;
            ctrl.wr_item_color = 1'b1;
         end
         rsfe_pkg::ST_READ: begin
            ctrl.frame_rd = status.item_inside;
         end
         rsfe_pkg::ST_SEED: begin
            ctrl.frame_rd = !status.fill_skip;
         end
         rsfe_pkg::ST_SEED_CHK: begin
            ctrl.frame_wr  = status.qual;
            ctrl.push      = status.qual;
            ctrl.count_one = status.qual;
         end
         rsfe_pkg::ST_POP: begin
            ctrl.pop = !status.level_zero;
         end
         rsfe_pkg::ST_LOAD: begin
            ctrl.load_cur = 1'b1;
            ctrl.dir_clr  = 1'b1;
         end
         rsfe_pkg::ST_NBR: begin
            ctrl.use_item = 1'b0;
            ctrl.frame_rd = status.nbr_ok;
            ctrl.dir_inc  = !status.nbr_ok && !status.last_dir;
         end
         rsfe_pkg::ST_CHECK: begin
            ctrl.use_item  = 1'b0;
            ctrl.frame_wr  = status.qual;
            ctrl.push      = status.qual;
            ctrl.count_inc = status.qual;
            ctrl.dir_inc   = !status.last_dir;
         end
         rsfe_pkg::ST_RESULT: begin
            ctrl.rsp_load = status.out_free;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

[src/region_seed_fill_engine.sv]
`timescale 1ns / 1ps

// Seed-fill engine over a WIDTH x HEIGHT RGB888 frame held in on-chip memory.
// A request word writes a pixel (mode 0), starts a fill at a seed (mode 1) or
// reads a pixel (mode 2); every request returns exactly one response word.
// Flood fill (fill_kind 0) paints the 4-connected region equal to
// target_color; boundary fill (fill_kind 1) paints the 8-connected region
// that is neither target_color nor paint_color. Pending pixels sit on a
// coordinate stack in memory, and a pixel is painted when pushed. A write or
// read request passes through its own state and then the result state, which
// loads the response register; an unused-mode request goes straight to the
// result state. The block returns to idle when the response is loaded.
// A fill reads and tests the seed, then for each painted pixel pops it and
// loads it as the current pixel, skips each neighbor off the frame, and reads
// and then tests each neighbor in the frame, one neighbor at a time, since
// every neighbor check shares the single frame memory port pair. The block
// takes no new request until the current one has finished; the response
// register lets it accept the next request while the last response still
// waits. Out-of-frame requests are harmless: writes drop, reads and fills
// answer zero. The user must write registers only while idle; the block itself does not enforce this.
module region_seed_fill_engine #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_pos_x,
   input  logic [6:0]  req_pos_y,
   input  logic [23:0] req_pixel_color,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_read_color,
   output logic [14:0] rsp_painted_count,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int XW    = $clog2(WIDTH);
   localparam int YW    = $clog2(HEIGHT);
   localparam int CELLS = WIDTH * HEIGHT;
   localparam int CW    = $clog2(CELLS);
   localparam int LW    = $clog2(CELLS + 1);
   localparam int SW    = XW + YW;

   // Configuration registers
   logic                                 fill_kind_ff;
   logic [rsfe_pkg::COLOR_W-1:0]         paint_color_ff;
   logic [rsfe_pkg::COLOR_W-1:0]         target_color_ff;

   // Latched request
   rsfe_pkg::rsfe_mode_type              mode_ff;
   logic                                 inside_ff;
   logic [XW-1:0]                        item_x_ff;
   logic [YW-1:0]                        item_y_ff;
   logic [rsfe_pkg::COLOR_W-1:0]         color_ff;

   // Fill walk state
   logic [XW-1:0]                        cur_x_ff;
   logic [YW-1:0]                        cur_y_ff;
   logic [rsfe_pkg::DIR_W-1:0]           dir_ff;
   logic [LW-1:0]                        level_ff;
   logic [rsfe_pkg::COUNT_W-1:0]         count_ff;

   // Response register
   logic                                 rsp_valid_ff;
   logic [rsfe_pkg::COLOR_W-1:0]         rsp_read_color_ff;
   logic [rsfe_pkg::COUNT_W-1:0]         rsp_painted_count_ff;

   // Memories
   logic [rsfe_pkg::COLOR_W-1:0]         frame_mem [CELLS];
   logic [SW-1:0]                        stack_mem [CELLS];
   logic [rsfe_pkg::COLOR_W-1:0]         frame_q_ff;
   logic [SW-1:0]                        stack_q_ff;

   rsfe_pkg::rsfe_status_type            status;
   rsfe_pkg::rsfe_ctrl_type              ctrl;
   rsfe_pkg::rsfe_step_type              step;

   logic                                 accept;
   logic                                 req_inside;
   logic [31:0]                          req_x_wide;
   logic [31:0]                          req_y_wide;
   logic [XW-1:0]                        base_x;
   logic [YW-1:0]                        base_y;
   logic [XW-1:0]                        nbr_x;
   logic [YW-1:0]                        nbr_y;
   logic                                 nbr_inside;
   logic [CW-1:0]                        addr;
   logic [rsfe_pkg::COLOR_W-1:0]         wr_color;
   logic [CW-1:0]                        push_idx;
   logic [LW-1:0]                        level_dec;
   logic                                 qual;
   logic                                 last_dir;

   assign accept     = req_valid && req_ready;
   assign req_x_wide = 32'(req_pos_x);
   assign req_y_wide = 32'(req_pos_y);
   assign req_inside = (req_x_wide < 32'(WIDTH)) && (req_y_wide < 32'(HEIGHT));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_kind_ff    <= 1'b0;
         paint_color_ff  <= rsfe_pkg::PAINT_RESET;
         target_color_ff <= rsfe_pkg::TARGET_RESET;
      end else if (csr_we) begin
         case (rsfe_pkg::rsfe_csr_type'(csr_index))
            rsfe_pkg::CSR_FILL_KIND:    fill_kind_ff    <= csr_wdata[0];
            rsfe_pkg::CSR_PAINT_COLOR:  paint_color_ff  <= csr_wdata;
            rsfe_pkg::CSR_TARGET_COLOR: target_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request word; coordinates are only used when in the frame
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= rsfe_pkg::rsfe_mode_type'(req_mode);
         inside_ff <= req_inside;
         item_x_ff <= req_x_wide[XW-1:0];
         item_y_ff <= req_y_wide[YW-1:0];
         color_ff  <= req_pixel_color;
      end
   end

   // Shared coordinate unit: the request position, or the current pixel
   // stepped toward the neighbor under test
   assign base_x = ctrl.use_item ? item_x_ff : cur_x_ff;
   assign base_y = ctrl.use_item ? item_y_ff : cur_y_ff;
   assign step   = ctrl.use_item ? rsfe_pkg::rsfe_step_type'('0)
                                 : rsfe_pkg::dir_step(dir_ff);

   rsfe_nbr_unit #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_nbr (
      .base_x   (base_x),
      .base_y   (base_y),
      .step     (step),
      .nbr_x    (nbr_x),
      .nbr_y    (nbr_y),
      .in_frame (nbr_inside),
      .addr     (addr)
   );

   // Frame memory: one write port, one registered read port
   assign wr_color = ctrl.wr_item_color ? color_ff : paint_color_ff;

   always_ff @(posedge clock) begin
      if (ctrl.frame_wr) begin
         frame_mem[addr] <= wr_color;
      end
      if (ctrl.frame_rd) begin
         frame_q_ff <= frame_mem[addr];
      end
   end

   // Pending-pixel stack
   assign push_idx  = level_ff[CW-1:0];
   assign level_dec = level_ff - LW'(1);

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         stack_mem[push_idx] <= {nbr_y, nbr_x};
      end
      if (ctrl.pop) begin
         stack_q_ff <= stack_mem[level_dec[CW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (ctrl.push) begin
         level_ff <= level_ff + LW'(1);
      end else if (ctrl.pop) begin
         level_ff <= level_dec;
      end
   end

   // Current pixel, neighbor direction and painted count
   always_ff @(posedge clock) begin
      if (ctrl.load_cur) begin
         cur_x_ff <= stack_q_ff[XW-1:0];
         cur_y_ff <= stack_q_ff[SW-1:XW];
      end
      if (ctrl.dir_clr) begin
         dir_ff <= '0;
      end else if (ctrl.dir_inc) begin
         dir_ff <= dir_ff + rsfe_pkg::DIR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || accept) begin
         count_ff <= '0;
      end else if (ctrl.count_one) begin
         count_ff <= rsfe_pkg::COUNT_W'(1);
      end else if (ctrl.count_inc) begin
         count_ff <= count_ff + rsfe_pkg::COUNT_W'(1);
      end
   end

   // Pixel test against the registered read data
   assign qual = fill_kind_ff ? (frame_q_ff != target_color_ff) &&
                                (frame_q_ff != paint_color_ff)
                              : (frame_q_ff == target_color_ff);

   assign last_dir = fill_kind_ff ? (dir_ff == rsfe_pkg::DIR_LAST_BOUNDARY)
                                  : (dir_ff == rsfe_pkg::DIR_LAST_FLOOD);

   always_comb begin
      status             = '0;
      status.accept      = accept;
      status.req_mode    = rsfe_pkg::rsfe_mode_type'(req_mode);
      status.item_inside = inside_ff;
      status.fill_skip   = !inside_ff ||
                           (!fill_kind_ff && (paint_color_ff == target_color_ff));
      status.qual        = qual;
      status.nbr_ok      = nbr_inside;
      status.last_dir    = last_dir;
      status.level_zero  = (level_ff == '0);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   rsfe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Response register: load when the slot is free, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_read_color_ff    <= (mode_ff == rsfe_pkg::MODE_READ && inside_ff) ?
                                 frame_q_ff : '0;
         rsp_painted_count_ff <= (mode_ff == rsfe_pkg::MODE_FILL) ? count_ff : '0;
      end
   end

   assign req_ready         = ctrl.req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_color    = rsp_read_color_ff;
   assign rsp_painted_count = rsp_painted_count_ff;

   // Checks
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(CELLS))
      else $error("stack level beyond frame size");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> level_ff != '0)
      else $error("pop from empty stack");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> level_ff < LW'(CELLS))
      else $error("push onto full stack");

   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_wr |-> (32'(addr) < 32'(CELLS)) && nbr_inside)
      else $error("frame write outside the frame");

   a_drained_on_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> level_ff == '0)
      else $error("response issued with pixels still pending");

endmodule

[verif/rsfe_frame_checker.sv]
`timescale 1ns / 1ps

module rsfe_frame_checker #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 128
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [rsfe_pkg::MODE_W-1:0]  req_mode,
   input  logic [rsfe_pkg::POS_W-1:0]   req_pos_x,
   input  logic [rsfe_pkg::POS_W-1:0]   req_pos_y,
   input  logic [rsfe_pkg::COLOR_W-1:0] req_pixel_color,

   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [rsfe_pkg::COLOR_W-1:0] rsp_read_color,
   input  logic [rsfe_pkg::COUNT_W-1:0] rsp_painted_count,

   input  logic                         csr_we,
   input  logic [rsfe_pkg::CSR_W-1:0]   csr_index,
   input  logic [rsfe_pkg::COLOR_W-1:0] csr_wdata,

   output int                           mismatch_count,
   output int                           replies_owed
);

   localparam int CELLS  = WIDTH * HEIGHT;
   localparam int CELL_W = $clog2(CELLS);

   typedef struct packed {
      logic [rsfe_pkg::COLOR_W-1:0] read_color;
      logic [rsfe_pkg::COUNT_W-1:0] painted_count;
   } reply_type;

   // Shadow of the frame, the pending-pixel stack and the three registers.
   logic [rsfe_pkg::COLOR_W-1:0] frame_copy [CELLS];
   logic [CELL_W-1:0]            pending_cells [CELLS];
   logic                         boundary_kind;
   logic [rsfe_pkg::COLOR_W-1:0] paint_value;
   logic [rsfe_pkg::COLOR_W-1:0] target_value;

   reply_type                    owed [$];
   reply_type                    due;

   function automatic logic paintable(input int pix);
      if (!boundary_kind) begin
         return frame_copy[pix] == target_value;
      end
      return frame_copy[pix] != target_value && frame_copy[pix] != paint_value;
   endfunction

   // Paint the region around a seed and return how many pixels changed.
   function automatic int paint_region(input int sx, input int sy);
      int count;
      int depth;
      int pix;
      int cx;
      int cy;
      int nx;
      int ny;
      int ncell;
      if (sx >= WIDTH || sy >= HEIGHT) begin
         return 0;
      end
      if (!boundary_kind && paint_value == target_value) begin
         return 0;
      end
      pix = sy * WIDTH + sx;
      if (!paintable(pix)) begin
         return 0;
      end
      frame_copy[pix] = paint_value;
      pending_cells[0] = pix[CELL_W-1:0];
      depth = 1;
      count = 1;
      while (depth > 0) begin
         depth = depth - 1;
         pix = int'(pending_cells[depth]);
         cx = pix % WIDTH;
         cy = pix / WIDTH;
         for (ny = cy - 1; ny <= cy + 1; ny++) begin
            for (nx = cx - 1; nx <= cx + 1; nx++) begin
               // drop the pixel itself, anything off the frame, and diagonals when flooding
               if (nx == cx && ny == cy) begin
                  continue;
               end
               if (nx < 0 || ny < 0 || nx >= WIDTH || ny >= HEIGHT) begin
                  continue;
               end
               if (!boundary_kind && nx != cx && ny != cy) begin
                  continue;
               end
               ncell = ny * WIDTH + nx;
               if (paintable(ncell)) begin
                  frame_copy[ncell] = paint_value;
                  count = count + 1;
                  pending_cells[depth] = ncell[CELL_W-1:0];
                  depth = depth + 1;
               end
            end
         end
      end
      return count;
   endfunction

   function automatic reply_type predict_reply(input rsfe_pkg::rsfe_mode_type mode,
                                               input int x, input int y,
                                               input logic [rsfe_pkg::COLOR_W-1:0] color);
      reply_type r;
      logic      on_frame;
      int        painted;
      r = '0;
      on_frame = x < WIDTH && y < HEIGHT;
      case (mode)
         rsfe_pkg::MODE_WRITE: begin
            if (on_frame) begin
               frame_copy[y * WIDTH + x] = color;
            end
         end
         rsfe_pkg::MODE_FILL: begin
            painted = paint_region(x, y);
            r.painted_count = painted[rsfe_pkg::COUNT_W-1:0];
         end
         rsfe_pkg::MODE_READ: begin
            if (on_frame) begin
               r.read_color = frame_copy[y * WIDTH + x];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         boundary_kind  = 1'b0;
         paint_value    = rsfe_pkg::PAINT_RESET;
         target_value   = rsfe_pkg::TARGET_RESET;
         mismatch_count = 0;
         owed.delete();
      end else begin
         // retire the oldest owed word first; its request is always older
         if (rsp_valid && rsp_ready) begin
            if (owed.size() == 0) begin
               $error("response word with nothing owed: read_color %h, painted_count %0d",
                      rsp_read_color, rsp_painted_count);
               mismatch_count++;
            end else begin
               due = owed.pop_front();
               if (rsp_read_color !== due.read_color) begin
                  $error("read_color: expected %h, got %h", due.read_color, rsp_read_color);
                  mismatch_count++;
               end
               if (rsp_painted_count !== due.painted_count) begin
                  $error("painted_count: expected %0d, got %0d",
                         due.painted_count, rsp_painted_count);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            case (rsfe_pkg::rsfe_csr_type'(csr_index))
               rsfe_pkg::CSR_FILL_KIND:    begin boundary_kind = csr_wdata[0]; end
               rsfe_pkg::CSR_PAINT_COLOR:  begin paint_value = csr_wdata; end
               rsfe_pkg::CSR_TARGET_COLOR: begin target_value = csr_wdata; end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            owed.push_back(predict_reply(rsfe_pkg::rsfe_mode_type'(req_mode),
                                         int'(req_pos_x), int'(req_pos_y),
                                         req_pixel_color));
         end
      end
      replies_owed = owed.size();
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int WIDTH  = 128;
   localparam int HEIGHT = 128;

   // Only the 16 x 16 corner of the frame is used. Walls sit on every eighth
   // row and column, so the corner is closed off as 2 x 2 rooms of 7 x 7;
   // no fill leaves it, and every pixel a fill or a read touches is written.
   localparam int FIELD = 16;
   localparam int GRID  = 8;
   localparam logic [rsfe_pkg::COLOR_W-1:0] WALL_RGB  = 24'hFFFFFF;
   localparam logic [rsfe_pkg::COLOR_W-1:0] FLOOR_RGB = 24'h000000;

   localparam int PHASE_WORDS    = 65;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int TAIL_CYCLES    = 20;
   localparam int CYCLE_LIMIT    = 2000000;

   logic                         clock;
   logic                         reset;

   logic                         req_valid;
   logic                         req_ready;
   rsfe_pkg::rsfe_mode_type      req_mode;
   logic [rsfe_pkg::POS_W-1:0]   req_pos_x;
   logic [rsfe_pkg::POS_W-1:0]   req_pos_y;
   logic [rsfe_pkg::COLOR_W-1:0] req_pixel_color;

   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [rsfe_pkg::COLOR_W-1:0] rsp_read_color;
   logic [rsfe_pkg::COUNT_W-1:0] rsp_painted_count;

   logic                         csr_we;
   rsfe_pkg::rsfe_csr_type       csr_index;
   logic [rsfe_pkg::COLOR_W-1:0] csr_wdata;

   int                           mismatch_count;
   int                           replies_owed;

   // Knobs shared between the sender and the receiver processes.
   int                           send_idle_pct;
   int                           stall_pct;
   bit                           holdoff_request;
   int                           cycle_count;

   // Register values currently loaded, for picking colors that matter.
   logic [rsfe_pkg::COLOR_W-1:0] cur_paint;
   logic [rsfe_pkg::COLOR_W-1:0] cur_target;

   region_seed_fill_engine #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) i_dut (.*);

   rsfe_frame_checker #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: a hung handshake or a lost response word ends up here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver: stall at the current rate, or hold off for a long stretch on
   // request so the block backs up and stops taking request words.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            repeat (HOLDOFF_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic bit on_grid_line(input int x, input int y);
      return (x % GRID == GRID - 1) || (y % GRID == GRID - 1);
   endfunction

   // Offer one request word and hold it until the block takes it. Entered and
   // left just after a falling edge; valid is touched once per edge.
   task automatic send_word(input rsfe_pkg::rsfe_mode_type mode, input int x, input int y,
                            input logic [rsfe_pkg::COLOR_W-1:0] color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_pos_x       <= x[rsfe_pkg::POS_W-1:0];
      req_pos_y       <= y[rsfe_pkg::POS_W-1:0];
      req_pixel_color <= color;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed response word has come back.
   task automatic drain_words();
      req_valid <= 1'b0;
      @(negedge clock);
      while (replies_owed != 0) begin
         @(negedge clock);
      end
   endtask

   // Load all three registers on an idle block, one per cycle, with the
   // write enable held high across the burst.
   task automatic load_settings(input logic boundary,
                                input logic [rsfe_pkg::COLOR_W-1:0] paint,
                                input logic [rsfe_pkg::COLOR_W-1:0] target);
      drain_words();
      csr_we    <= 1'b1;
      csr_index <= rsfe_pkg::CSR_FILL_KIND;
      csr_wdata <= {{(rsfe_pkg::COLOR_W-1){1'b0}}, boundary};
      @(negedge clock);
      csr_index <= rsfe_pkg::CSR_PAINT_COLOR;
      csr_wdata <= paint;
      @(negedge clock);
      csr_index <= rsfe_pkg::CSR_TARGET_COLOR;
      csr_wdata <= target;
      @(negedge clock);
      csr_we     <= 1'b0;
      cur_paint  = paint;
      cur_target = target;
   endtask

   // Random traffic: mostly fills seeded inside rooms and writes that keep the
   // walls standing, plus reads and the unused mode.
   task automatic run_phase(input int words, input int idle_pct, input int stall,
                            input bit with_holdoff);
      int                           n;
      int                           pick;
      int                           px;
      int                           py;
      rsfe_pkg::rsfe_mode_type      mode;
      logic [rsfe_pkg::COLOR_W-1:0] color;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (n = 0; n < words; n++) begin
         if (with_holdoff && n == 20) begin
            holdoff_request = 1'b1;
         end
         pick  = $urandom_range(99);
         px    = $urandom_range(FIELD - 1);
         py    = $urandom_range(FIELD - 1);
         color = rsfe_pkg::COLOR_W'($urandom_range(24'hFFFFFF, 0));
         if (pick < 30) begin
            mode = rsfe_pkg::MODE_FILL;
            // aim most seeds at room interiors, where the regions live
            if ($urandom_range(3) != 0) begin
               px = GRID * $urandom_range(FIELD / GRID - 1) + $urandom_range(GRID - 2);
               py = GRID * $urandom_range(FIELD / GRID - 1) + $urandom_range(GRID - 2);
            end
         end else if (pick < 70) begin
            mode = rsfe_pkg::MODE_WRITE;
            if (on_grid_line(px, py)) begin
               color = WALL_RGB;
            end else begin
               case ($urandom_range(5))
                  0: begin color = FLOOR_RGB; end
                  1: begin color = cur_paint; end
                  2: begin color = cur_target; end
                  default: begin
                  end
               endcase
            end
         end else if (pick < 95) begin
            mode = rsfe_pkg::MODE_READ;
         end else begin
            mode = rsfe_pkg::MODE_NONE;
         end
         send_word(mode, px, py, color);
      end
   endtask

   initial begin
      int                           x;
      int                           y;
      logic [rsfe_pkg::COLOR_W-1:0] boundary_paint;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = rsfe_pkg::MODE_WRITE;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pixel_color = '0;
      csr_we          = 1'b0;
      csr_index       = rsfe_pkg::CSR_FILL_KIND;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      holdoff_request = 1'b0;
      cur_paint       = rsfe_pkg::PAINT_RESET;
      cur_target      = rsfe_pkg::TARGET_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lay out the whole corner first, so no fill or read ever meets a
      // pixel that was never written.
      for (y = 0; y < FIELD; y++) begin
         for (x = 0; x < FIELD; x++) begin
            send_word(rsfe_pkg::MODE_WRITE, x, y,
                      on_grid_line(x, y) ? WALL_RGB : FLOOR_RGB);
         end
      end

      // Directed, reset settings: flood fill, green paint over black floor.
      send_word(rsfe_pkg::MODE_READ, 0, 0, '0);
      send_word(rsfe_pkg::MODE_FILL, 0, 0, '0);            // corner room, frame edge as barrier
      send_word(rsfe_pkg::MODE_FILL, 0, 0, '0);            // seed already painted
      send_word(rsfe_pkg::MODE_READ, 6, 6, '0);
      send_word(rsfe_pkg::MODE_FILL, 7, 3, '0);            // seed on a wall
      send_word(rsfe_pkg::MODE_WRITE, 7, 7, FLOOR_RGB);    // open a wall crossing
      send_word(rsfe_pkg::MODE_FILL, 7, 7, '0);            // walls on all four sides
      send_word(rsfe_pkg::MODE_WRITE, 11, 11, WALL_RGB);   // island inside the last room
      send_word(rsfe_pkg::MODE_FILL, 14, 14, '0);
      send_word(rsfe_pkg::MODE_READ, 11, 11, '0);
      send_word(rsfe_pkg::MODE_NONE, 15, 15, WALL_RGB);
      send_word(rsfe_pkg::MODE_READ, 15, 15, '0);
      send_word(rsfe_pkg::MODE_WRITE, 15, 0, WALL_RGB);
      send_word(rsfe_pkg::MODE_READ, 0, 15, '0);

      // Flood with paint equal to target: nothing may change.
      load_settings(1'b0, FLOOR_RGB, FLOOR_RGB);
      send_word(rsfe_pkg::MODE_FILL, 10, 10, '0);
      send_word(rsfe_pkg::MODE_READ, 10, 10, '0);

      // Boundary fill with white as border; the open crossing leaks diagonally.
      load_settings(1'b1, 24'h0000FF, WALL_RGB);
      send_word(rsfe_pkg::MODE_WRITE, 7, 7, FLOOR_RGB);
      send_word(rsfe_pkg::MODE_FILL, 9, 9, '0);
      send_word(rsfe_pkg::MODE_FILL, 9, 9, '0);            // now paint, so a barrier
      send_word(rsfe_pkg::MODE_FILL, 7, 0, '0);            // seed on the border color
      send_word(rsfe_pkg::MODE_READ, 7, 7, '0);
      send_word(rsfe_pkg::MODE_FILL, 8, 0, '0);

      // Random phases: walk the registers through their extremes and vary
      // the idling on both sides.
      load_settings(1'b0, rsfe_pkg::COLOR_W'($urandom_range(24'hFFFFFE, 1)), FLOOR_RGB);
      run_phase(PHASE_WORDS, 0, 0, 1'b0);

      boundary_paint = rsfe_pkg::COLOR_W'($urandom_range(24'hFFFFFE, 1));
      load_settings(1'b1, boundary_paint, WALL_RGB);
      run_phase(PHASE_WORDS, 63, 0, 1'b0);

      // Recolor what the boundary pass painted into wall color.
      load_settings(1'b0, WALL_RGB, boundary_paint);
      run_phase(PHASE_WORDS, 0, 63, 1'b1);

      load_settings(1'b1, FLOOR_RGB, WALL_RGB);
      run_phase(PHASE_WORDS, 15, 15, 1'b0);

      load_settings(1'b0, rsfe_pkg::COLOR_W'($urandom_range(24'hFFFFFE, 1)), FLOOR_RGB);
      run_phase(PHASE_WORDS, 0, 0, 1'b1);

      drain_words();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[region_seed_fill_engine.f]
src/rsfe_pkg.sv
src/rsfe_nbr_unit.sv
src/rsfe_seq.sv
src/region_seed_fill_engine.sv
verif/rsfe_frame_checker.sv
verif/tb_top.sv
